/* hdl/ccs_pkg.sv */
// Shared types and constants for the comment stripper.
package ccs_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_TAB_DEPTH_DEF = 255;
    localparam int QUEUE_DEPTH_DEF   = 4;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EAT_NEWLINE      = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLLECT_COMMENTS = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_CODE    = 2'd0;
    localparam logic [1:0] KIND_COMMENT = 2'd1;
    localparam logic [1:0] KIND_CLEAR   = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    // One result without its last flag.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
    } res_t;

    // All results caused by one input item: one, or two when 'two' is set.
    typedef struct packed {
        logic two;
        res_t r0;
        res_t r1;
    } rec_t;

    // Status of the output side, for checking.
    typedef struct packed {
        logic pend_valid;
        logic take;
    } back_stat_t;

endpackage

/* hdl/ccs_front.sv */
// Front end: configuration registers and the per-byte classifier state machine.
module ccs_front
    import ccs_pkg::*;
#(
    parameter int MAX_TAB_DEPTH = MAX_TAB_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic                   cfg_data,
    input  logic                   item_valid,
    input  logic [7:0]             in_byte,
    input  logic                   is_end,
    output logic                   wr_en,
    output rec_t                   wr_rec
);

    localparam int TW = $clog2(MAX_TAB_DEPTH + 1);

    localparam logic [3:0] M_CODE      = 4'd0;
    localparam logic [3:0] M_SLASH     = 4'd1;
    localparam logic [3:0] M_LINE_LEAD = 4'd2;
    localparam logic [3:0] M_LINE_BODY = 4'd3;
    localparam logic [3:0] M_BLK_TABS  = 4'd4;
    localparam logic [3:0] M_BLK_NLS   = 4'd5;
    localparam logic [3:0] M_BLK_BODY  = 4'd6;
    localparam logic [3:0] M_BLK_STAR  = 4'd7;
    localparam logic [3:0] M_AFTER_BLK = 4'd8;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [TW-1:0] td;
        logic [TW-1:0] tts;
        logic          emit;
    } body_t;

    // One byte of block comment text: tab stripping and depth tracking.
    function automatic body_t body_step(input logic [7:0] c, input logic [TW-1:0] td,
                                        input logic [TW-1:0] tts);
        body_t r;
        r.td   = td;
        r.tts  = tts;
        r.emit = 1'b1;
        if (c == CH_TAB && tts != '0)
        begin
            r.tts  = tts - TW'(1);
            r.emit = 1'b0;
        end
        else if (c == CH_NL)
        begin
            r.tts = td;
        end
        else if (tts != '0)
        begin
            r.td  = td - tts;
            r.tts = '0;
        end
        return r;
    endfunction

    logic          eat_reg;
    logic          collect_reg;
    logic [3:0]    mode_reg, mode_next;
    logic          esc_reg, esc_next;
    logic [TW-1:0] td_reg, td_next;
    logic [TW-1:0] tts_reg, tts_next;

    logic          e0_v, e1_v;
    res_t          e0, e1;
    logic          keep0, keep1;
    body_t         b_c, b_star, b_c2;

    assign b_c    = body_step(in_byte, td_reg, tts_reg);
    assign b_star = body_step(CH_STAR, td_reg, tts_reg);
    assign b_c2   = body_step(in_byte, b_star.td, b_star.tts);

    always_comb
    begin
        mode_next = mode_reg;
        esc_next  = esc_reg;
        td_next   = td_reg;
        tts_next  = tts_reg;
        e0_v      = 1'b0;
        e0        = '{kind: KIND_CODE, ch: 8'h00};
        e1_v      = 1'b0;
        e1        = '{kind: KIND_CODE, ch: 8'h00};

        if (is_end)
        begin
            if (mode_reg == M_SLASH)
            begin
                e0_v = 1'b1;
                e0   = '{kind: KIND_CODE, ch: CH_SLASH};
                e1_v = 1'b1;
                e1   = '{kind: KIND_END, ch: 8'h00};
            end
            else if (mode_reg == M_BLK_STAR)
            begin
                e0_v = 1'b1;
                e0   = '{kind: KIND_COMMENT, ch: CH_STAR};
                e1_v = 1'b1;
                e1   = '{kind: KIND_END, ch: 8'h00};
            end
            else
            begin
                e0_v = 1'b1;
                e0   = '{kind: KIND_END, ch: 8'h00};
            end
            mode_next = M_CODE;
            esc_next  = 1'b0;
            td_next   = '0;
            tts_next  = '0;
        end
        else
        begin
            case (mode_reg)
                M_SLASH:
                begin
                    if (in_byte == CH_SLASH)
                    begin
                        mode_next = M_LINE_LEAD;
                    end
                    else if (in_byte == CH_STAR)
                    begin
                        e0_v      = 1'b1;
                        e0        = '{kind: KIND_CLEAR, ch: 8'h00};
                        td_next   = '0;
                        tts_next  = '0;
                        mode_next = M_BLK_TABS;
                    end
                    else
                    begin
                        mode_next = M_CODE;
                        e0_v      = 1'b1;
                        e0        = '{kind: KIND_CODE, ch: CH_SLASH};
                        e1_v      = 1'b1;
                        e1        = '{kind: KIND_CODE, ch: in_byte};
                    end
                end
                M_LINE_LEAD, M_LINE_BODY:
                begin
                    if (mode_reg == M_LINE_BODY || (in_byte != CH_SPACE && in_byte != CH_TAB))
                    begin
                        // Leading blanks start the body with no escape pending.
                        mode_next = M_LINE_BODY;
                        e0_v      = 1'b1;
                        e0        = '{kind: KIND_COMMENT, ch: in_byte};
                        if (in_byte == CH_NL && !(mode_reg == M_LINE_BODY && esc_reg))
                        begin
                            e1_v      = !eat_reg;
                            e1        = '{kind: KIND_CODE, ch: in_byte};
                            mode_next = M_CODE;
                            esc_next  = 1'b0;
                        end
                        else if (in_byte == CH_BSL)
                        begin
                            esc_next = !(mode_reg == M_LINE_BODY && esc_reg);
                        end
                        else
                        begin
                            esc_next = 1'b0;
                        end
                    end
                end
                M_BLK_TABS, M_BLK_NLS, M_BLK_BODY:
                begin
                    if (mode_reg == M_BLK_TABS && in_byte == CH_TAB)
                    begin
                        if (td_reg < TW'(MAX_TAB_DEPTH))
                        begin
                            td_next = td_reg + TW'(1);
                        end
                    end
                    else if (mode_reg == M_BLK_TABS && in_byte == CH_NL && td_reg == '0)
                    begin
                        mode_next = M_BLK_NLS;
                    end
                    else if (mode_reg == M_BLK_NLS && in_byte == CH_NL)
                    begin
                        mode_next = M_BLK_NLS;
                    end
                    else if (in_byte == CH_STAR)
                    begin
                        mode_next = M_BLK_STAR;
                    end
                    else
                    begin
                        mode_next = M_BLK_BODY;
                        td_next   = b_c.td;
                        tts_next  = b_c.tts;
                        e0_v      = b_c.emit;
                        e0        = '{kind: KIND_COMMENT, ch: in_byte};
                    end
                end
                M_BLK_STAR:
                begin
                    if (in_byte == CH_SLASH)
                    begin
                        mode_next = M_AFTER_BLK;
                    end
                    else
                    begin
                        // The held star is comment text; then this byte is taken as usual.
                        e0_v = 1'b1;
                        e0   = '{kind: KIND_COMMENT, ch: CH_STAR};
                        if (in_byte == CH_STAR)
                        begin
                            mode_next = M_BLK_STAR;
                            td_next   = b_star.td;
                            tts_next  = b_star.tts;
                        end
                        else
                        begin
                            mode_next = M_BLK_BODY;
                            td_next   = b_c2.td;
                            tts_next  = b_c2.tts;
                            e1_v      = b_c2.emit;
                            e1        = '{kind: KIND_COMMENT, ch: in_byte};
                        end
                    end
                end
                M_AFTER_BLK:
                begin
                    mode_next = M_CODE;
                    if (!(in_byte == CH_NL && eat_reg))
                    begin
                        if (in_byte == CH_SLASH)
                        begin
                            mode_next = M_SLASH;
                        end
                        else
                        begin
                            e0_v = 1'b1;
                            e0   = '{kind: KIND_CODE, ch: in_byte};
                        end
                    end
                end
                default:
                begin
                    mode_next = M_CODE;
                    if (in_byte == CH_SLASH)
                    begin
                        mode_next = M_SLASH;
                    end
                    else
                    begin
                        e0_v = 1'b1;
                        e0   = '{kind: KIND_CODE, ch: in_byte};
                    end
                end
            endcase
        end
    end

    // Comment text and clear markers are dropped when collection is off.
    assign keep0 = e0_v && (collect_reg || e0.kind == KIND_CODE || e0.kind == KIND_END);
    assign keep1 = e1_v && (collect_reg || e1.kind == KIND_CODE || e1.kind == KIND_END);

    always_comb
    begin
        if (keep0)
        begin
            wr_rec.r0  = e0;
            wr_rec.r1  = e1;
            wr_rec.two = keep1;
        end
        else
        begin
            wr_rec.r0  = e1;
            wr_rec.r1  = e0;
            wr_rec.two = 1'b0;
        end
    end

    assign wr_en = item_valid && (keep0 || keep1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eat_reg     <= 1'b0;
            collect_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_EAT_NEWLINE:      eat_reg     <= cfg_data;
                CFG_COLLECT_COMMENTS: collect_reg <= cfg_data;
                default:              eat_reg     <= eat_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_CODE;
            esc_reg  <= 1'b0;
            td_reg   <= '0;
            tts_reg  <= '0;
        end
        else if (item_valid)
        begin
            mode_reg <= mode_next;
            esc_reg  <= esc_next;
            td_reg   <= td_next;
            tts_reg  <= tts_next;
        end
    end

endmodule

/* hdl/ccs_queue.sv */
// Small queue of per-item result records between the front and back ends.
module ccs_queue
    import ccs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  rec_t wr_rec,
    input  logic rd_en,
    output rec_t rd_rec,
    output logic q_empty,
    output logic q_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rec_t          mem [DEPTH];
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic [CW-1:0] count_reg;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        r = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
        return r;
    endfunction

    assign rd_rec  = mem[rptr_reg];
    assign q_empty = (count_reg == '0);
    assign q_full  = (count_reg == CW'(DEPTH));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wptr_reg] <= wr_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wptr_reg <= bump(wptr_reg);
            end
            if (rd_en)
            begin
                rptr_reg <= bump(rptr_reg);
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

/* hdl/ccs_back.sv */
// Back end: splits records into single results and holds the output register.
module ccs_back
    import ccs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  rec_t       rd_rec,
    output logic       rd_en,
    input  logic       pop,
    output logic       empty,
    output logic [1:0] kind,
    output logic [7:0] out_byte,
    output logic       last,
    output back_stat_t stat
);

    logic out_valid_reg;
    logic pend_valid_reg;
    res_t out_reg;
    logic last_reg;
    res_t pend_reg;
    logic pop_fire;

    assign pop_fire = pop && out_valid_reg;
    assign rd_en    = !q_empty && !pend_valid_reg && (!out_valid_reg || pop);

    assign empty           = !out_valid_reg;
    assign kind            = out_reg.kind;
    assign out_byte        = out_reg.ch;
    assign last            = last_reg;
    assign stat.pend_valid = pend_valid_reg;
    assign stat.take       = rd_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            out_valid_reg  <= 1'b1;
            pend_valid_reg <= rd_rec.two;
        end
        else if (pop_fire)
        begin
            out_valid_reg  <= pend_valid_reg;
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            out_reg  <= rd_rec.r0;
            last_reg <= !rd_rec.two;
            pend_reg <= rd_rec.r1;
        end
        else if (pop_fire && pend_valid_reg)
        begin
            out_reg  <= pend_reg;
            last_reg <= 1'b1;
        end
    end

endmodule

/* hdl/c_comment_stripper.sv */
// Top level of the C and C++ comment stripper.
//
//   Channel   Signals                           Moves
//   input     push, full, in_byte, is_end       one source byte or end mark
//   result    empty, pop, kind, out_byte, last  one code/comment/clear/end result
//   config    cfg_valid, cfg_ready, cfg_index,  one register write
//             cfg_data
//
// One input byte is accepted every cycle while full is low; each byte yields zero, one
// or two results, and the output side delivers one result per cycle while pop is high, so
// the sustained rate is one item per cycle except for items that cause two results, which
// hold the output side for both. A result's record is written into the queue at the edge
// that accepts its byte and moves on to the output register once the output side is free.
// The byte classifier is a state machine whose results are combinational; the record queue
// between it and the output stage absorbs stalls on the result side.
// Reset is asynchronous and active low and needs no clearing pass; cfg_ready is always high.
module c_comment_stripper
    import ccs_pkg::*;
#(
    parameter int MAX_TAB_DEPTH = MAX_TAB_DEPTH_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [7:0]             in_byte,
    input  logic                   is_end,
    output logic                   empty,
    input  logic                   pop,
    output logic [1:0]             kind,
    output logic [7:0]             out_byte,
    output logic                   last,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic                   cfg_data
);

    logic       item_valid;
    logic       wr_en;
    rec_t       wr_rec;
    logic       rd_en;
    rec_t       rd_rec;
    logic       q_empty;
    logic       q_full;
    back_stat_t stat;

    // A byte transfer completes whenever the record queue has room.
    assign full       = q_full;
    assign item_valid = push && !q_full;
    assign cfg_ready  = 1'b1;

    ccs_front #(
        .MAX_TAB_DEPTH(MAX_TAB_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item_valid(item_valid),
        .in_byte   (in_byte),
        .is_end    (is_end),
        .wr_en     (wr_en),
        .wr_rec    (wr_rec)
    );

    ccs_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (wr_en),
        .wr_rec (wr_rec),
        .rd_en  (rd_en),
        .rd_rec (rd_rec),
        .q_empty(q_empty),
        .q_full (q_full)
    );

    ccs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .rd_rec  (rd_rec),
        .rd_en   (rd_en),
        .pop     (pop),
        .empty   (empty),
        .kind    (kind),
        .out_byte(out_byte),
        .last    (last),
        .stat    (stat)
    );

    // A held second result implies the first one is on the outputs.
    a_pend_shown: assert property (@(posedge clk) disable iff (!rst_n)
        stat.pend_valid |-> !empty)
        else $error("second result held while output register is empty");

    // While a second result is held, the shown result is not the last of its item.
    a_pend_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        stat.pend_valid |-> !last)
        else $error("first of a result pair marked last");

    // Taking the first of a pair leaves the second on the outputs next cycle.
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last) |=> !empty)
        else $error("second result of an item lost");

    // The output stage only takes records that are in the queue.
    a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        stat.take |-> !q_empty)
        else $error("record taken from an empty queue");

endmodule

/* verif/ccs_checker.sv */
// Result checker for the comment stripper: predicts every result and compares it on transfer.
`timescale 1ns / 1ps
module ccs_checker
    import ccs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic                   full,
    input  logic [7:0]             in_byte,
    input  logic                   is_end,
    input  logic                   empty,
    input  logic                   pop,
    input  logic [1:0]             kind,
    input  logic [7:0]             out_byte,
    input  logic                   last,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic                   cfg_data,
    output int                     mismatch_count,
    output int                     results_pending
);

    localparam int         TAB_LIMIT = MAX_TAB_DEPTH_DEF;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef enum logic [3:0] {
        SCAN_CODE,
        SCAN_SLASH,
        SCAN_LINE_LEAD,
        SCAN_LINE_BODY,
        SCAN_BLK_TABS,
        SCAN_BLK_NLS,
        SCAN_BLK_BODY,
        SCAN_BLK_STAR,
        SCAN_AFTER_BLK
    } scan_mode_e;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic       last;
    } strip_result_t;

    scan_mode_e    mode;
    logic          esc;
    logic [7:0]    depth;
    logic [7:0]    strip_left;
    logic          eat_nl;
    logic          collect;

    strip_result_t expected_results[$];
    strip_result_t step_out[2];
    int            step_cnt;
    strip_result_t want;
    strip_result_t got;

    task automatic emit(input logic [1:0] k, input logic [7:0] c);
        if ((k == KIND_COMMENT || k == KIND_CLEAR) && !collect)
            return;
        if (step_cnt >= 2)
            return;
        step_out[step_cnt].kind = k;
        step_out[step_cnt].ch   = (k == KIND_CODE || k == KIND_COMMENT) ? c : 8'h00;
        step_out[step_cnt].last = 1'b0;
        step_cnt++;
    endtask

    task automatic code_char(input logic [7:0] c);
        if (c == CH_SLASH)
            mode = SCAN_SLASH;
        else
            emit(KIND_CODE, c);
    endtask

    task automatic line_char(input logic [7:0] c);
        if (c == CH_NL && !esc)
        begin
            emit(KIND_COMMENT, c);
            if (!eat_nl)
                emit(KIND_CODE, c);
            mode = SCAN_CODE;
            esc  = 1'b0;
        end
        else
        begin
            emit(KIND_COMMENT, c);
            esc = (c == CH_BSLASH) ? !esc : 1'b0;
        end
    endtask

    task automatic body_char(input logic [7:0] c);
        if (c == CH_TAB && strip_left != 0)
        begin
            strip_left = strip_left - 8'd1;
        end
        else
        begin
            if (c == CH_NL)
            begin
                strip_left = depth;
            end
            else if (strip_left != 0)
            begin
                depth      = depth - strip_left;
                strip_left = 8'd0;
            end
            emit(KIND_COMMENT, c);
        end
    endtask

    task automatic blk_char(input logic [7:0] c);
        if (c == CH_STAR)
        begin
            mode = SCAN_BLK_STAR;
        end
        else
        begin
            mode = SCAN_BLK_BODY;
            body_char(c);
        end
    endtask

    task automatic clear_scan();
        mode       = SCAN_CODE;
        esc        = 1'b0;
        depth      = 8'd0;
        strip_left = 8'd0;
    endtask

    // Works out the results of one accepted byte and queues them, with the last flag set on the final one.
    task automatic predict_item(input logic [7:0] c, input logic e);
        strip_result_t r;
        step_cnt = 0;
        if (e)
        begin
            if (mode == SCAN_SLASH)
                emit(KIND_CODE, CH_SLASH);
            else if (mode == SCAN_BLK_STAR)
                body_char(CH_STAR);
            clear_scan();
            emit(KIND_END, 8'h00);
        end
        else
        begin
            case (mode)
                SCAN_SLASH:
                begin
                    if (c == CH_SLASH)
                    begin
                        mode = SCAN_LINE_LEAD;
                    end
                    else if (c == CH_STAR)
                    begin
                        emit(KIND_CLEAR, 8'h00);
                        depth      = 8'd0;
                        strip_left = 8'd0;
                        mode       = SCAN_BLK_TABS;
                    end
                    else
                    begin
                        mode = SCAN_CODE;
                        emit(KIND_CODE, CH_SLASH);
                        emit(KIND_CODE, c);
                    end
                end
                SCAN_LINE_LEAD:
                begin
                    if (c != CH_SPACE && c != CH_TAB)
                    begin
                        esc  = 1'b0;
                        mode = SCAN_LINE_BODY;
                        line_char(c);
                    end
                end
                SCAN_LINE_BODY:
                    line_char(c);
                SCAN_BLK_TABS:
                begin
                    if (c == CH_TAB)
                    begin
                        if (depth < TAB_LIMIT)
                            depth = depth + 8'd1;
                    end
                    else if (c == CH_NL && depth == 0)
                    begin
                        mode = SCAN_BLK_NLS;
                    end
                    else
                    begin
                        blk_char(c);
                    end
                end
                SCAN_BLK_NLS:
                begin
                    if (c != CH_NL)
                        blk_char(c);
                end
                SCAN_BLK_BODY:
                    blk_char(c);
                SCAN_BLK_STAR:
                begin
                    if (c == CH_SLASH)
                    begin
                        mode = SCAN_AFTER_BLK;
                    end
                    else
                    begin
                        body_char(CH_STAR);
                        blk_char(c);
                    end
                end
                SCAN_AFTER_BLK:
                begin
                    mode = SCAN_CODE;
                    if (!(c == CH_NL && eat_nl))
                        code_char(c);
                end
                default:
                begin
                    mode = SCAN_CODE;
                    code_char(c);
                end
            endcase
        end
        for (int i = 0; i < step_cnt; i++)
        begin
            r      = step_out[i];
            r.last = (i == step_cnt - 1);
            expected_results.push_back(r);
        end
    endtask

    task automatic report(input bit has_want);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            if (has_want)
                $display("mismatch: expected kind=%0d byte=%02h last=%0b, got kind=%0d byte=%02h last=%0b",
                         want.kind, want.ch, want.last, got.kind, got.ch, got.last);
            else
                $display("mismatch: unexpected result kind=%0d byte=%02h last=%0b",
                         got.kind, got.ch, got.last);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_scan();
            eat_nl  = 1'b0;
            collect = 1'b1;
            expected_results.delete();
            mismatch_count  = 0;
            results_pending = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                got.kind = kind;
                got.ch   = out_byte;
                got.last = last;
                if (expected_results.size() == 0)
                begin
                    report(1'b0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                        report(1'b1);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_EAT_NEWLINE)
                    eat_nl = cfg_data;
                else if (cfg_index == CFG_COLLECT_COMMENTS)
                    collect = cfg_data;
            end
            if (push && !full)
                predict_item(in_byte, is_end);
            results_pending = expected_results.size();
        end
    end

endmodule

/* verif/tb_c_comment_stripper.sv */
// Testbench top for the comment stripper: stimulus, idling, register settings and verdict.
`timescale 1ns / 1ps
module tb_c_comment_stripper;
    import ccs_pkg::*;

    // Items of the random part; the directed part before it sends about 560 more.
    localparam int ITEM_TARGET    = 1150;
    localparam int SEGMENTS       = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    // Extra wait after the last predicted result has been taken.
    localparam int SETTLE_CYCLES  = 8;
    localparam int SAT_TABS       = 258;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   push      = 1'b0;
    logic [7:0]             in_byte   = 8'h00;
    logic                   is_end    = 1'b0;
    logic                   pop       = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_EAT_NEWLINE;
    logic                   cfg_data  = 1'b0;

    logic                   full;
    logic                   empty;
    logic [1:0]             kind;
    logic [7:0]             out_byte;
    logic                   last;
    logic                   cfg_ready;

    int mismatches;
    int pending;
    int send_idle_pct = 22;
    int recv_idle_pct = 53;
    int sent_items    = 0;
    int stall_cycles  = 0;

    always #5 clk = ~clk;

    c_comment_stripper uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_byte   (in_byte),
        .is_end    (is_end),
        .empty     (empty),
        .pop       (pop),
        .kind      (kind),
        .out_byte  (out_byte),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ccs_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .in_byte         (in_byte),
        .is_end          (is_end),
        .empty           (empty),
        .pop             (pop),
        .kind            (kind),
        .out_byte        (out_byte),
        .last            (last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatches),
        .results_pending (pending)
    );

    // The receiver decides afresh every cycle whether it takes a result. A pop while
    // the block is empty is harmless, so no transfer tracking is needed here.
    always @(posedge clk)
    begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // The watchdog restarts on any transfer; a long run of cycles without one means
    // the block hung or an expected result never arrived.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offers one byte and returns at the edge where its transfer took place. Push is
    // only lowered when the sender decides to idle, so back-to-back bytes keep it high.
    task automatic send_item(input logic [7:0] b, input logic e);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        in_byte <= b;
        is_end  <= e;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sent_items++;
    endtask

    // Stops the sender and waits until every predicted result has been taken. The
    // first edge makes sure the checker has seen the final transfer before the
    // count is read.
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Writes both registers in two consecutive transfers; valid stays high between them.
    task automatic apply_settings(input logic eat, input logic collect);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_EAT_NEWLINE;
        cfg_data  <= eat;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= CFG_COLLECT_COMMENTS;
        cfg_data  <= collect;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly printable text, with the characters the stripper reacts to mixed in.
    function automatic logic [7:0] text_char();
        case ($urandom_range(0, 11))
            0:       return CH_SLASH;
            1:       return CH_STAR;
            2:       return CH_TAB;
            3:       return CH_SPACE;
            4:       return CH_BSLASH;
            5:       return CH_NL;
            default: return 8'($urandom_range(8'h21, 8'h7E));
        endcase
    endfunction

    // One random piece of source text. Half of the pieces are comments, mostly well-formed,
    // with random content so that every mode is reached; the rest is plain code, a lone
    // slash, an end mark or raw noise. A block comment is sometimes left open,
    // which lets the following pieces run inside it.
    task automatic send_chunk();
        int pick;
        int lines;
        pick = $urandom_range(0, 99);
        if (pick < 22)
        begin
            repeat ($urandom_range(1, 6))
                send_item(text_char(), 1'b0);
        end
        else if (pick < 44)
        begin
            // Line comment: optional blanks, a body with the odd backslash, a newline.
            send_item(CH_SLASH, 1'b0);
            send_item(CH_SLASH, 1'b0);
            repeat ($urandom_range(0, 3))
                send_item($urandom_range(0, 1) ? CH_TAB : CH_SPACE, 1'b0);
            repeat ($urandom_range(0, 8))
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    send_item(CH_BSLASH, 1'b0);
                    if ($urandom_range(0, 1))
                        send_item(CH_NL, 1'b0);
                end
                else
                begin
                    send_item(text_char(), 1'b0);
                end
            end
            send_item(CH_NL, 1'b0);
        end
        else if (pick < 72)
        begin
            // Block comment: indent tabs, leading newlines, indented lines, usually a close.
            send_item(CH_SLASH, 1'b0);
            send_item(CH_STAR, 1'b0);
            repeat ($urandom_range(0, 3))
                send_item(CH_TAB, 1'b0);
            repeat ($urandom_range(0, 2))
                send_item(CH_NL, 1'b0);
            lines = $urandom_range(1, 3);
            for (int i = 0; i < lines; i++)
            begin
                repeat ($urandom_range(0, 4))
                    send_item(CH_TAB, 1'b0);
                repeat ($urandom_range(0, 5))
                    send_item(text_char(), 1'b0);
                if (i != lines - 1)
                    send_item(CH_NL, 1'b0);
            end
            if ($urandom_range(0, 9) != 0)
            begin
                repeat ($urandom_range(1, 2))
                    send_item(CH_STAR, 1'b0);
                send_item(CH_SLASH, 1'b0);
                if ($urandom_range(0, 1))
                    send_item(CH_NL, 1'b0);
            end
        end
        else if (pick < 80)
        begin
            send_item(CH_SLASH, 1'b0);
            send_item(text_char(), 1'b0);
        end
        else if (pick < 86)
        begin
            // The byte that comes with an end mark is ignored, so it is fully random.
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end
        else
        begin
            repeat ($urandom_range(1, 4))
                send_item(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    initial
    begin
        int seg;
        int seg_end;

        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values written explicitly, then the directed part.
        apply_settings(1'b0, 1'b1);

        // Extreme byte values, then a lone slash that passes with the byte after it.
        send_item(8'h00, 1'b0);     send_item(8'hFF, 1'b0);
        send_item(CH_SLASH, 1'b0);  send_item("b", 1'b0);
        // Line comment with dropped leading blanks and a newline escaped by a backslash.
        send_item(CH_SLASH, 1'b0);  send_item(CH_SLASH, 1'b0);
        send_item(CH_TAB, 1'b0);    send_item(CH_SPACE, 1'b0);
        send_item(CH_BSLASH, 1'b0); send_item(CH_NL, 1'b0);
        send_item(CH_NL, 1'b0);
        // Block comment indented two tabs; the next line has only one, which lowers the
        // depth, and a doubled star before the close exercises the held star.
        send_item(CH_SLASH, 1'b0);  send_item(CH_STAR, 1'b0);
        send_item(CH_TAB, 1'b0);    send_item(CH_TAB, 1'b0);
        send_item("z", 1'b0);       send_item(CH_NL, 1'b0);
        send_item(CH_TAB, 1'b0);    send_item("y", 1'b0);
        send_item(CH_STAR, 1'b0);   send_item(CH_STAR, 1'b0);
        send_item(CH_SLASH, 1'b0);  send_item(CH_NL, 1'b0);
        // End of input with a held slash, then with a held star inside a comment.
        send_item(CH_SLASH, 1'b0);  send_item(8'h00, 1'b1);
        send_item(CH_SLASH, 1'b0);  send_item(CH_STAR, 1'b0);
        send_item(CH_STAR, 1'b0);   send_item(8'hFF, 1'b1);
        // Unclosed block comment with no indent: the leading newlines are dropped.
        send_item(CH_SLASH, 1'b0);  send_item(CH_STAR, 1'b0);
        send_item(CH_NL, 1'b0);     send_item(CH_NL, 1'b0);
        send_item("k", 1'b0);       send_item(8'h00, 1'b1);
        wait_idle();

        // Indent deeper than the tab depth can count: it saturates, and after the
        // newline only the saturated number of tabs is stripped.
        send_item(CH_SLASH, 1'b0);
        send_item(CH_STAR, 1'b0);
        repeat (SAT_TABS)
            send_item(CH_TAB, 1'b0);
        send_item("x", 1'b0);
        send_item(CH_NL, 1'b0);
        repeat (SAT_TABS)
            send_item(CH_TAB, 1'b0);
        send_item("y", 1'b0);
        send_item(CH_STAR, 1'b0);
        send_item(CH_SLASH, 1'b0);

        // Random part: each segment runs under its own register setting and idling
        // phase, and halfway through the sender holds off until the block has drained.
        sent_items = 0;
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            wait_idle();
            if (seg < 3)
            begin
                send_idle_pct = 22;
                recv_idle_pct = 53;
            end
            else if (seg < 6)
            begin
                send_idle_pct = 53;
                recv_idle_pct = 22;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            apply_settings(seg[0], !seg[1]);
            seg_end = (ITEM_TARGET * (seg + 1)) / SEGMENTS;
            while (sent_items < seg_end - (ITEM_TARGET / SEGMENTS) / 2)
                send_chunk();
            wait_idle();
            while (sent_items < seg_end)
                send_chunk();
        end

        wait_idle();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
hdl/ccs_pkg.sv
hdl/ccs_front.sv
hdl/ccs_queue.sv
hdl/ccs_back.sv
hdl/c_comment_stripper.sv
verif/ccs_checker.sv
verif/tb_c_comment_stripper.sv
